/* hdl/switch_control_register_file_assert.svh */
// Assertion macros used by the register file checker.
`ifndef SWITCH_CONTROL_REGISTER_FILE_ASSERT_SVH
`define SWITCH_CONTROL_REGISTER_FILE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define SCRF_AST_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("register file assertion failed");

// Next-cycle implication, disabled while reset is low.
`define SCRF_AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("register file assertion failed");

`endif

/* hdl/scrf_pkg.sv */
package scrf_pkg;

    localparam int MAX_LINKS_DEF     = 8;
    localparam int MAX_NODE_BITS_DEF = 16;

    // status bits available on the connected input
    localparam int LINK_CONN_W = 8;

    // register numbers
    localparam logic [15:0] REG_SCRATCH = 16'h0003;
    localparam logic [15:0] REG_NODE_ID = 16'h0005;
    localparam logic [15:0] REG_DIR0    = 16'h000c;
    localparam logic [15:0] REG_NETDIR0 = 16'h0020;
    localparam logic [15:0] REG_STATE0  = 16'h0080;

    // access kind
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // device modes
    localparam logic MODE_OLD = 1'b0;
    localparam logic MODE_NEW = 1'b1;

    // state word bit positions
    localparam int ST_SYM_OLD_LSB = 8;
    localparam int ST_SYM_NEW_LSB = 11;
    localparam int ST_CONN_A      = 25;
    localparam int ST_CONN_B      = 26;
    localparam int ST_FIVE_WIRE   = 30;
    localparam int ST_ENABLE      = 31;

    // network/direction word bit positions
    localparam int ND_NET_LSB   = 4;
    localparam int ND_ROUTE_LSB = 8;

    typedef enum logic [1:0] {
        CFG_DEVICE_MODE = 2'd0,
        CFG_NODE_BITS   = 2'd1,
        CFG_LINK_COUNT  = 2'd2
    } t_cfg_idx;

    // Route field is ceil(log2(nb)) + 2 bits wide.
    function automatic logic [5:0] route_mask(input logic [4:0] nb);
        logic [5:0] m;
        if (nb <= 5'd1) begin
            m = 6'h03;
        end else if (nb == 5'd2) begin
            m = 6'h07;
        end else if (nb <= 5'd4) begin
            m = 6'h0f;
        end else if (nb <= 5'd8) begin
            m = 6'h1f;
        end else begin
            m = 6'h3f;
        end
        return m;
    endfunction

endpackage

/* hdl/switch_control_register_file.sv */
// An accepted access goes through the input register, then the result register, to
// its result word, and is held up only while the result side stalls.
// Throughput: one access per cycle unless the result side stalls; the decode and
// field pack between the two registers, with register updates on the same edge
// as the result load. Reset (synchronous, active low): pipeline empty, mode 1,
// 16 node bits, 4 links, and every control register cleared to zero.
module switch_control_register_file
    import scrf_pkg::*;
#(
    parameter int MAX_LINKS     = MAX_LINKS_DEF,
    parameter int MAX_NODE_BITS = MAX_NODE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_data,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_kind,
    input  logic [15:0] i_reg_number,
    input  logic [31:0] i_write_data,
    input  logic [7:0]  i_link_connected,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_access_ok,
    output logic [31:0] o_read_data
);

    localparam int LINK_IW = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;

    // configuration
    logic       r_device_mode;
    logic [4:0] r_node_bits;
    logic [3:0] r_link_count;

    // control registers
    logic [MAX_NODE_BITS-1:0] r_node_id;
    logic [31:0]              r_scratch;
    logic [3:0]               r_dim_dir   [MAX_NODE_BITS];
    logic [1:0]               r_link_net  [MAX_LINKS];
    logic [5:0]               r_link_route[MAX_LINKS];
    logic [10:0]              r_link_tok  [MAX_LINKS];
    logic [10:0]              r_link_sym  [MAX_LINKS];
    logic                     r_link_five [MAX_LINKS];
    logic                     r_link_en   [MAX_LINKS];

    // input stage
    logic        r_in_valid;
    logic        r_kind;
    logic [15:0] r_num;
    logic [31:0] r_wdata;
    logic [7:0]  r_conn;

    // result stage
    logic        r_out_valid;
    logic        r_access_ok;
    logic [31:0] r_read_data;

    logic        out_load;
    logic        proc_write;
    logic [4:0]  eff_nb;
    logic [5:0]  eff_links;
    logic [5:0]  ndir_sum;
    logic [1:0]  ndir;
    logic [16:0] nb_mask17;
    logic [MAX_NODE_BITS-1:0] node_mask;
    logic [5:0]  rmask;
    logic [15:0] dir_off;
    logic [15:0] net_off;
    logic [15:0] st_off;
    logic        dir_sel;
    logic        hit_node;
    logic        hit_scr;
    logic        hit_dir;
    logic        hit_net;
    logic        hit_st;
    logic        hit_any;
    logic [LINK_IW-1:0] link_idx;
    logic        conn_bit;
    logic [31:0] dir_data;
    logic        n_access_ok;
    logic [31:0] n_read_data;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_access_ok = r_access_ok;
    assign o_read_data = r_read_data;

    assign out_load   = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !out_load;
    assign proc_write = r_in_valid && out_load && (r_kind == KIND_WRITE);

    // effective configuration
    assign eff_nb    = (r_node_bits > 5'(MAX_NODE_BITS)) ? 5'(MAX_NODE_BITS) : r_node_bits;
    assign eff_links = ({2'b00, r_link_count} > 6'(MAX_LINKS)) ?
                       6'(MAX_LINKS) : {2'b00, r_link_count};
    assign ndir_sum  = {1'b0, eff_nb} + 6'd7;
    assign ndir      = ndir_sum[4:3];
    assign nb_mask17 = (17'd1 << eff_nb) - 17'd1;
    assign node_mask = nb_mask17[MAX_NODE_BITS-1:0];
    assign rmask     = route_mask(eff_nb);

    // address decode
    assign dir_off  = r_num - REG_DIR0;
    assign net_off  = r_num - REG_NETDIR0;
    assign st_off   = r_num - REG_STATE0;
    assign dir_sel  = dir_off[0];

    assign hit_node = (r_num == REG_NODE_ID);
    assign hit_scr  = (r_num == REG_SCRATCH) && (r_device_mode == MODE_OLD);
    assign hit_dir  = (r_device_mode == MODE_NEW) && (r_num >= REG_DIR0) &&
                      (dir_off < {14'd0, ndir});
    assign hit_net  = (r_num >= REG_NETDIR0) && (net_off < {10'd0, eff_links});
    assign hit_st   = (r_num >= REG_STATE0) && (st_off < {10'd0, eff_links});
    assign hit_any  = hit_node || hit_scr || hit_dir || hit_net || hit_st;

    assign link_idx = hit_net ? net_off[LINK_IW-1:0] : st_off[LINK_IW-1:0];
    assign conn_bit = (st_off < 16'(LINK_CONN_W)) ? r_conn[st_off[2:0]] : 1'b0;

    // direction register read: nibble k of register r is dimension 8r+k
    always_comb begin
        dir_data = '0;
        for (int d = 0; d < MAX_NODE_BITS; d++) begin
            if ((1'(d / 8) == dir_sel) && (5'(d) < eff_nb)) begin
                dir_data[4*(d%8) +: 4] = r_dim_dir[d];
            end
        end
    end

    always_comb begin
        n_read_data = '0;
        if (hit_node) begin
            n_read_data = 32'(r_node_id & node_mask);
        end else if (hit_scr) begin
            n_read_data = r_scratch;
        end else if (hit_dir) begin
            n_read_data = dir_data;
        end else if (hit_net) begin
            n_read_data[ND_NET_LSB +: 2]   = r_link_net[link_idx];
            n_read_data[ND_ROUTE_LSB +: 6] = r_link_route[link_idx] & rmask;
        end else if (hit_st) begin
            if (r_device_mode == MODE_OLD) begin
                n_read_data[3:0]                = r_link_tok[link_idx][3:0];
                n_read_data[ST_SYM_OLD_LSB +: 4] = r_link_sym[link_idx][3:0];
            end else begin
                n_read_data[10:0]                 = r_link_tok[link_idx];
                n_read_data[ST_SYM_NEW_LSB +: 11] = r_link_sym[link_idx];
                n_read_data[ST_CONN_A]            = conn_bit;
                n_read_data[ST_CONN_B]            = conn_bit;
            end
            n_read_data[ST_FIVE_WIRE] = r_link_five[link_idx];
            n_read_data[ST_ENABLE]    = r_link_en[link_idx];
        end
        if (r_kind == KIND_WRITE) begin
            n_read_data = '0;
        end
        n_access_ok = hit_any;
    end

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_mode <= MODE_NEW;
            r_node_bits   <= 5'd16;
            r_link_count  <= 4'd4;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_DEVICE_MODE: r_device_mode <= i_cfg_data[0];
                CFG_NODE_BITS:   r_node_bits   <= i_cfg_data;
                CFG_LINK_COUNT:  r_link_count  <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_kind  <= i_kind;
            r_num   <= i_reg_number;
            r_wdata <= i_write_data;
            r_conn  <= i_link_connected;
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_in_valid) begin
            r_access_ok <= n_access_ok;
            r_read_data <= n_read_data;
        end
    end

    // register writes, committed as the word moves to the result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id <= '0;
            r_scratch <= '0;
            for (int d = 0; d < MAX_NODE_BITS; d++) begin
                r_dim_dir[d] <= '0;
            end
            for (int l = 0; l < MAX_LINKS; l++) begin
                r_link_net[l]   <= '0;
                r_link_route[l] <= '0;
                r_link_tok[l]   <= '0;
                r_link_sym[l]   <= '0;
                r_link_five[l]  <= 1'b0;
                r_link_en[l]    <= 1'b0;
            end
        end else if (proc_write) begin
            if (hit_node) begin
                r_node_id <= r_wdata[MAX_NODE_BITS-1:0] & node_mask;
            end else if (hit_scr) begin
                r_scratch <= r_wdata;
            end else if (hit_dir) begin
                for (int d = 0; d < MAX_NODE_BITS; d++) begin
                    if ((1'(d / 8) == dir_sel) && (5'(d) < eff_nb)) begin
                        r_dim_dir[d] <= r_wdata[4*(d%8) +: 4];
                    end
                end
            end else if (hit_net) begin
                r_link_net[link_idx]   <= r_wdata[ND_NET_LSB +: 2];
                r_link_route[link_idx] <= r_wdata[ND_ROUTE_LSB +: 6] & rmask;
            end else if (hit_st) begin
                if (r_device_mode == MODE_OLD) begin
                    r_link_tok[link_idx] <= {7'd0, r_wdata[3:0]};
                    r_link_sym[link_idx] <= {7'd0, r_wdata[ST_SYM_OLD_LSB +: 4]};
                end else begin
                    r_link_tok[link_idx] <= r_wdata[10:0];
                    r_link_sym[link_idx] <= r_wdata[ST_SYM_NEW_LSB +: 11];
                end
                r_link_five[link_idx] <= r_wdata[ST_FIVE_WIRE];
                r_link_en[link_idx]   <= r_wdata[ST_ENABLE];
            end
        end
    end

endmodule

/* hdl/scrf_checker.sv */
`include "switch_control_register_file_assert.svh"

module scrf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_stall,
    input logic        i_out_valid,
    input logic        i_out_stall,
    input logic        i_access_ok,
    input logic [31:0] i_read_data
);

    // a held result word keeps its payload
    `SCRF_AST_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid && $stable(i_access_ok) && $stable(i_read_data))

    // a failed access never carries data
    `SCRF_AST_IMP(a_fail_zero, i_clk, i_rst_n, i_out_valid && !i_access_ok, i_read_data == 32'h0)

    // input backs up only behind a stalled result
    `SCRF_AST_IMP(a_stall_cause, i_clk, i_rst_n, i_in_stall, i_out_valid && i_out_stall)

    // nothing comes out on the cycle right after reset
    `SCRF_AST_IMP(a_reset_empty, i_clk, i_rst_n, !$past(i_rst_n), !i_out_valid)

endmodule

bind switch_control_register_file scrf_checker u_scrf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_access_ok (o_access_ok),
    .i_read_data (o_read_data)
);

/* test/switch_control_register_file_tb.sv */
`timescale 1ns / 1ps

module switch_control_register_file_tb;
    import scrf_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int SEGMENT_WORDS  = 135;

    typedef struct packed {
        logic        ok;
        logic [31:0] data;
    } t_reply;

    logic        i_clk;
    logic        i_rst_n          = 1'b0;
    logic        i_cfg_valid      = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index      = '0;
    logic [4:0]  i_cfg_data       = '0;
    logic        i_in_valid       = 1'b0;
    logic        o_in_stall;
    logic        i_kind           = KIND_READ;
    logic [15:0] i_reg_number     = '0;
    logic [31:0] i_write_data     = '0;
    logic [7:0]  i_link_connected = '0;
    logic        o_out_valid;
    logic        i_out_stall      = 1'b0;
    logic        o_access_ok;
    logic [31:0] o_read_data;

    switch_control_register_file dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_kind           (i_kind),
        .i_reg_number     (i_reg_number),
        .i_write_data     (i_write_data),
        .i_link_connected (i_link_connected),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_access_ok      (o_access_ok),
        .o_read_data      (o_read_data)
    );

    // shadow copy of the register file and its settings
    logic        sh_mode       = MODE_NEW;
    logic [4:0]  sh_node_bits  = 5'd16;
    logic [3:0]  sh_link_count = 4'd4;
    logic [15:0] sh_node_id    = '0;
    logic [31:0] sh_scratch    = '0;
    logic [3:0]  sh_dim_dir [16];
    logic [1:0]  sh_net     [8];
    logic [5:0]  sh_route   [8];
    logic [10:0] sh_tok_dly [8];
    logic [10:0] sh_sym_dly [8];
    logic        sh_five    [8];
    logic        sh_enable  [8];

    t_reply replies_due [$];
    t_reply want_reply;
    int     mismatches     = 0;
    int     stuck_cycles   = 0;
    int     send_idle_pct  = 0;
    int     recv_stall_pct = 0;
    int     hold_len       = 0;
    int     hold_req       = 0;
    int     hold_seen      = 0;
    int     hold_left      = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Applies one access to the shadow registers and returns the reply it should get.
    function automatic t_reply predict_access(input logic kind, input logic [15:0] num,
                                              input logic [31:0] wdata,
                                              input logic [7:0] conn);
        int         nb;
        int         links;
        int         ndir;
        int         rw;
        int         v;
        int         idx;
        int         dim;
        int         k;
        logic [15:0] id_mask;
        logic [5:0]  rmask;
        t_reply      r;
        nb      = (sh_node_bits > 5'd16) ? 16 : int'(sh_node_bits);
        links   = (sh_link_count > 4'd8) ? 8 : int'(sh_link_count);
        ndir    = (nb + 7) / 8;
        id_mask = 16'((32'd1 << nb) - 1);
        // route field is ceil(log2(nb)) + 2 bits
        rw = 2;
        v  = (nb > 0) ? nb - 1 : 0;
        while (v != 0) begin
            rw++;
            v = v >> 1;
        end
        rmask = 6'((32'd1 << rw) - 1);
        r = '0;
        if (num == REG_NODE_ID) begin
            r.ok = 1'b1;
            if (kind == KIND_WRITE) sh_node_id = wdata[15:0] & id_mask;
            else r.data = {16'd0, sh_node_id & id_mask};
        end else if (num == REG_SCRATCH && sh_mode == MODE_OLD) begin
            r.ok = 1'b1;
            if (kind == KIND_WRITE) sh_scratch = wdata;
            else r.data = sh_scratch;
        end else if (sh_mode == MODE_NEW && num >= REG_DIR0 && num < REG_DIR0 + ndir) begin
            r.ok = 1'b1;
            for (k = 0; k < 8; k++) begin
                dim = int'(num - REG_DIR0) * 8 + k;
                if (dim < nb) begin
                    if (kind == KIND_WRITE) sh_dim_dir[dim] = wdata[4*k +: 4];
                    else r.data[4*k +: 4] = sh_dim_dir[dim];
                end
            end
        end else if (num >= REG_NETDIR0 && num < REG_NETDIR0 + links) begin
            idx  = int'(num - REG_NETDIR0);
            r.ok = 1'b1;
            if (kind == KIND_WRITE) begin
                sh_net[idx]   = wdata[ND_NET_LSB +: 2];
                sh_route[idx] = wdata[ND_ROUTE_LSB +: 6] & rmask;
            end else begin
                r.data[ND_NET_LSB +: 2]   = sh_net[idx];
                r.data[ND_ROUTE_LSB +: 6] = sh_route[idx] & rmask;
            end
        end else if (num >= REG_STATE0 && num < REG_STATE0 + links) begin
            idx  = int'(num - REG_STATE0);
            r.ok = 1'b1;
            if (kind == KIND_WRITE) begin
                if (sh_mode == MODE_OLD) begin
                    sh_tok_dly[idx] = {7'd0, wdata[3:0]};
                    sh_sym_dly[idx] = {7'd0, wdata[ST_SYM_OLD_LSB +: 4]};
                end else begin
                    sh_tok_dly[idx] = wdata[10:0];
                    sh_sym_dly[idx] = wdata[ST_SYM_NEW_LSB +: 11];
                end
                sh_five[idx]   = wdata[ST_FIVE_WIRE];
                sh_enable[idx] = wdata[ST_ENABLE];
            end else begin
                if (sh_mode == MODE_OLD) begin
                    r.data[3:0]                = sh_tok_dly[idx][3:0];
                    r.data[ST_SYM_OLD_LSB +: 4] = sh_sym_dly[idx][3:0];
                end else begin
                    r.data[10:0]                 = sh_tok_dly[idx];
                    r.data[ST_SYM_NEW_LSB +: 11] = sh_sym_dly[idx];
                    r.data[ST_CONN_A]            = conn[idx];
                    r.data[ST_CONN_B]            = conn[idx];
                end
                r.data[ST_FIVE_WIRE] = sh_five[idx];
                r.data[ST_ENABLE]    = sh_enable[idx];
            end
        end
        return r;
    endfunction

    task automatic send_access(input logic kind, input logic [15:0] num,
                               input logic [31:0] wdata, input logic [7:0] conn);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_kind           <= kind;
        i_reg_number     <= num;
        i_write_data     <= wdata;
        i_link_connected <= conn;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        replies_due.push_back(predict_access(kind, num, wdata, conn));
    endtask

    task automatic wait_replies_done();
        i_in_valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_register(input t_cfg_idx idx, input logic [4:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_DEVICE_MODE: sh_mode       = value[0];
            CFG_NODE_BITS:   sh_node_bits  = value;
            CFG_LINK_COUNT:  sh_link_count = value[3:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [4:0] mode_v, input logic [4:0] nb_v,
                                 input logic [4:0] links_v);
        wait_replies_done();
        set_register(CFG_DEVICE_MODE, mode_v);
        set_register(CFG_NODE_BITS, nb_v);
        set_register(CFG_LINK_COUNT, links_v);
    endtask

    task automatic send_random_accesses(input int count);
        logic [15:0] num;
        logic [31:0] wdata;
        repeat (count) begin
            case ($urandom_range(9))
                0:       num = REG_NODE_ID;
                1:       num = REG_SCRATCH;
                2:       num = REG_DIR0 + 16'($urandom_range(2));
                3, 4:    num = REG_NETDIR0 + 16'($urandom_range(9));
                5, 6:    num = REG_STATE0 + 16'($urandom_range(9));
                7:       num = 16'($urandom_range(255));
                default: num = 16'($urandom);
            endcase
            case ($urandom_range(7))
                0:       wdata = '0;
                1:       wdata = '1;
                default: wdata = $urandom;
            endcase
            send_access($urandom_range(1) ? KIND_WRITE : KIND_READ, num, wdata,
                        8'($urandom));
        end
    endtask

    // reset layout: new mode, 16 node bits, 4 links
    task automatic test_default_layout();
        send_access(KIND_READ,  REG_NODE_ID,        32'h0,        8'h00);
        send_access(KIND_WRITE, REG_NODE_ID,        32'hffffffff, 8'h00);
        send_access(KIND_READ,  REG_NODE_ID,        32'h0,        8'h00);
        send_access(KIND_WRITE, REG_DIR0,           32'hffffffff, 8'h00);
        send_access(KIND_WRITE, REG_DIR0 + 16'd1,   32'h89abcdef, 8'h00);
        send_access(KIND_READ,  REG_DIR0,           32'h0,        8'h00);
        send_access(KIND_READ,  REG_DIR0 + 16'd1,   32'h0,        8'h00);
        send_access(KIND_READ,  REG_DIR0 + 16'd2,   32'h0,        8'h00);
        send_access(KIND_READ,  REG_SCRATCH,        32'h0,        8'h00);
        send_access(KIND_WRITE, REG_NETDIR0,        32'hffffffff, 8'h00);
        send_access(KIND_READ,  REG_NETDIR0,        32'h0,        8'h00);
        send_access(KIND_READ,  REG_NETDIR0 + 16'd3, 32'h0,       8'h00);
        send_access(KIND_WRITE, REG_NETDIR0 + 16'd4, 32'hffffffff, 8'h00);
        send_access(KIND_WRITE, REG_STATE0,         32'hffffffff, 8'h00);
        send_access(KIND_READ,  REG_STATE0,         32'h0,        8'hff);
        send_access(KIND_READ,  REG_STATE0 + 16'd3, 32'h0,        8'h08);
        send_access(KIND_READ,  REG_STATE0 + 16'd4, 32'h0,        8'hff);
        send_access(KIND_WRITE, 16'hffff,           32'hffffffff, 8'hff);
        send_access(KIND_READ,  16'h0000,           32'h0,        8'h00);
    endtask

    // old layout: scratch word mapped, direction registers gone, stale wide delays masked
    task automatic test_old_layout();
        apply_setting(5'(MODE_OLD), 5'd5, 5'd8);
        send_access(KIND_WRITE, REG_SCRATCH,        32'ha5a5c3c3, 8'h00);
        send_access(KIND_READ,  REG_SCRATCH,        32'h0,        8'h00);
        send_access(KIND_READ,  REG_STATE0,         32'h0,        8'hff);
        send_access(KIND_READ,  REG_DIR0,           32'h0,        8'h00);
        send_access(KIND_READ,  REG_NETDIR0,        32'h0,        8'h00);
        send_access(KIND_READ,  REG_STATE0 + 16'd7, 32'h0,        8'hff);
        send_access(KIND_READ,  REG_NODE_ID,        32'h0,        8'h00);
    endtask

    task automatic test_random_phases();
        int phase;
        int j;
        int seg;
        for (phase = 0; phase < 4; phase++) begin
            for (j = 0; j < 3; j++) begin
                seg = phase * 3 + j;
                case (seg)
                    0: apply_setting(5'(MODE_NEW), 5'd0, 5'd0);
                    1: apply_setting(5'(MODE_OLD), 5'd31, 5'd31);
                    2: apply_setting(5'(MODE_NEW), 5'd1, 5'd1);
                    3: apply_setting(5'(MODE_OLD), 5'd16, 5'd8);
                    4: apply_setting(5'(MODE_NEW), 5'd2, 5'd15);
                    default: apply_setting(5'($urandom_range(31)), 5'($urandom_range(31)),
                                           5'($urandom_range(31)));
                endcase
                case (phase)
                    0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
                    1: begin send_idle_pct = 65; recv_stall_pct <= 0;  end
                    2: begin send_idle_pct = 0;  recv_stall_pct <= 65; end
                    default: begin send_idle_pct = 28; recv_stall_pct <= 28; end
                endcase
                send_random_accesses(SEGMENT_WORDS);
            end
        end
    endtask

    // result side holds off while the sender keeps offering words
    task automatic test_receiver_holdoff();
        apply_setting(5'(MODE_NEW), 5'd9, 5'd6);
        send_idle_pct = 0;
        recv_stall_pct <= 0;
        hold_len <= 200;
        hold_req <= hold_req + 1;
        send_random_accesses(40);
    endtask

    task automatic test_sender_pause();
        send_idle_pct = 28;
        recv_stall_pct <= 28;
        send_random_accesses(30);
        wait_replies_done();
        send_random_accesses(30);
    endtask

    initial begin
        int i;
        for (i = 0; i < 16; i++) sh_dim_dir[i] = '0;
        for (i = 0; i < 8; i++) begin
            sh_net[i]     = '0;
            sh_route[i]   = '0;
            sh_tok_dly[i] = '0;
            sh_sym_dly[i] = '0;
            sh_five[i]    = 1'b0;
            sh_enable[i]  = 1'b0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_layout();
        test_old_layout();
        test_random_phases();
        test_receiver_holdoff();
        test_sender_pause();
        wait_replies_done();
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // result side stall: random, or a long hold-off when requested
    always @(posedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen   <= hold_req;
            hold_left   <= hold_len;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (replies_due.size() == 0) begin
                $display("%0t: result word with nothing expected: ok=%0b data=%08h",
                         $time, o_access_ok, o_read_data);
                mismatches++;
            end else begin
                want_reply = replies_due.pop_front();
                if (o_access_ok !== want_reply.ok) begin
                    $display("%0t: access_ok expected %0b actual %0b",
                             $time, want_reply.ok, o_access_ok);
                    mismatches++;
                end
                if (o_read_data !== want_reply.data) begin
                    $display("%0t: read_data expected %08h actual %08h",
                             $time, want_reply.data, o_read_data);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

endmodule
